@@ hw/rtl/edt_pkg.sv @@
// Shared types, codes and sizes for the indel edit-distance traceback block.
package edt_pkg;

  localparam int MAX_LEN_DEF = 16;

  // Configuration register indexes
  localparam logic REG_BASE_LEN   = 1'b0;
  localparam logic REG_TARGET_LEN = 1'b1;

  // Tie-mark bits kept per table cell
  localparam int MARK_INSERT_BIT = 0;
  localparam int MARK_REMOVE_BIT = 1;
  localparam int MARK_MATCH_BIT  = 2;

  // Result operation codes
  localparam logic [1:0] KIND_MATCH  = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_READ,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic init;
    logic base_we;
  } cell_ctl_t;

endpackage

@@ hw/rtl/edt_load_if.sv @@
// Load channel: one string position per transaction.
interface edt_load_if;
  logic       valid;
  logic       ready;
  logic [3:0] position;
  logic [7:0] base_symbol;
  logic [7:0] target_symbol;
  logic       last_load;

  modport source (output valid, position, base_symbol, target_symbol, last_load, input ready);
  modport sink   (input valid, position, base_symbol, target_symbol, last_load, output ready);
endinterface

@@ hw/rtl/edt_result_if.sv @@
// Result channel: one traceback operation per transaction.
interface edt_result_if;
  logic              valid;
  logic              ready;
  logic [1:0]        op_kind;
  logic [7:0]        op_symbol;
  logic signed [4:0] base_index;
  logic [5:0]        distance;
  logic              last_op;

  modport source (output valid, op_kind, op_symbol, base_index, distance, last_op, input ready);
  modport sink   (input valid, op_kind, op_symbol, base_index, distance, last_op, output ready);
endinterface

@@ hw/rtl/edt_cell.sv @@
// One table row cell: holds a base symbol, its running cost and its column of tie marks.
module edt_cell #(
  parameter int MAX_LEN  = edt_pkg::MAX_LEN_DEF,
  parameter int CELL_IDX = 0,
  localparam int LW = $clog2(MAX_LEN + 1),
  localparam int CW = $clog2(2 * MAX_LEN + 2)
) (
  input  logic                clk,
  input  logic                rst,
  input  edt_pkg::cell_ctl_t  ctl,
  input  logic [7:0]          load_sym,
  input  logic                i_valid,
  input  logic [LW-1:0]       i_x,
  input  logic [CW-1:0]       i_cost,
  input  logic [CW-1:0]       i_diag,
  input  logic [7:0]          i_sym,
  input  logic [LW-1:0]       rd_x,
  output logic                o_valid,
  output logic [LW-1:0]       o_x,
  output logic [CW-1:0]       o_cost,
  output logic [CW-1:0]       o_diag,
  output logic [7:0]          o_sym,
  output logic [7:0]          base_sym,
  output logic [CW-1:0]       cost,
  output logic [2:0]          rd_marks
);
  import edt_pkg::*;

  logic [2:0]    marks_mem [MAX_LEN+1];
  logic [CW-1:0] ins, rem, best_ir, best;
  logic          can_match;
  logic [2:0]    marks;

  always_comb begin
    ins       = i_cost + CW'(1);
    rem       = cost + CW'(1);
    can_match = (base_sym == i_sym);
    best_ir   = (ins < rem) ? ins : rem;
    best      = (can_match && (i_diag < best_ir)) ? i_diag : best_ir;
    marks                  = '0;
    marks[MARK_INSERT_BIT] = (ins == best);
    marks[MARK_REMOVE_BIT] = (rem == best);
    marks[MARK_MATCH_BIT]  = can_match && (i_diag == best);
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.init) begin
      o_valid <= 1'b0;
    end else begin
      o_valid <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.base_we) begin
      base_sym <= load_sym;
    end
    if (ctl.init) begin
      cost <= CW'(CELL_IDX + 1);
    end else if (i_valid) begin
      cost <= best;
    end
    // pass the column on; the old cost is the next row's diagonal
    o_x    <= i_x;
    o_cost <= best;
    o_diag <= cost;
    o_sym  <= i_sym;
  end

  always_ff @(posedge clk) begin
    if (i_valid) begin
      marks_mem[i_x] <= marks;
    end
    rd_marks <= marks_mem[rd_x];
  end

endmodule

@@ hw/rtl/indel_edit_distance_traceback.sv @@
// Load is ready only while no table fill or traceback runs.
// On last_load the cell chain fills the table, the wavefront passing one column per cycle
// through the row of cells. Traceback then steps through a mark memory read and then a decision
// for each result; output stalls hold it in the decision step. Reset clears control state and
// sets both lengths to 15; symbol stores and marks stay undefined until written.
module indel_edit_distance_traceback #(
  parameter int MAX_LEN = edt_pkg::MAX_LEN_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [4:0]   cfg_data,
  edt_load_if.sink     load,
  edt_result_if.source result
);
  import edt_pkg::*;

  localparam int LW  = $clog2(MAX_LEN + 1);
  localparam int CW  = $clog2(2 * MAX_LEN + 2);
  localparam int AW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CNW = $clog2(2 * MAX_LEN + 4);

  state_t state, state_next;

  logic [4:0]    base_length, target_length;
  logic [LW-1:0] blen_eff, tlen_eff, blen_q, tlen_q;
  logic [CNW-1:0] cnt, fill_end;
  logic [LW-1:0] tx, ty, nx, ny;
  logic [5:0]    dist_q;

  logic [7:0]    target_store [MAX_LEN];
  logic [AW-1:0] t_rd_addr;
  logic [7:0]    tsym_q;

  logic          f_valid;
  logic [LW-1:0] f_x;
  logic [CW-1:0] f_cost, f_diag;

  logic          c_valid [MAX_LEN];
  logic [LW-1:0] c_x     [MAX_LEN];
  logic [CW-1:0] c_cost  [MAX_LEN];
  logic [CW-1:0] c_diag  [MAX_LEN];
  logic [7:0]    c_sym   [MAX_LEN];
  logic [7:0]    c_bsym  [MAX_LEN];
  logic [CW-1:0] c_own   [MAX_LEN];
  logic [2:0]    c_marks [MAX_LEN];

  logic          load_fire, start, feed, fill_done, emit_fire;
  logic [AW-1:0] ysel, bsel;
  logic [2:0]    m_sel;
  logic [1:0]    kind;
  logic [7:0]    sym;
  logic [LW+5:0] tw;
  logic [CW+5:0] dw;

  assign blen_eff  = ({1'b0, base_length} > 6'(MAX_LEN)) ? LW'(MAX_LEN) : LW'(base_length);
  assign tlen_eff  = ({1'b0, target_length} > 6'(MAX_LEN)) ? LW'(MAX_LEN) : LW'(target_length);
  assign load.ready = (state == ST_IDLE);
  assign load_fire = load.valid && load.ready;
  assign start     = load_fire && load.last_load;
  assign fill_end  = CNW'(tlen_q) + CNW'(MAX_LEN + 2);
  assign feed      = (state == ST_FILL) && (cnt != '0) && (cnt <= CNW'(tlen_q));
  assign fill_done = (state == ST_FILL) && (cnt == fill_end);
  assign emit_fire = (state == ST_EMIT) && (!result.valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      base_length   <= 5'd15;
      target_length <= 5'd15;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASE_LEN:   base_length   <= cfg_data;
        REG_TARGET_LEN: target_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // target symbol store, one shared read port for feed and traceback
  assign t_rd_addr = (state == ST_FILL) ? AW'(cnt - CNW'(1)) : AW'(tx - LW'(1));

  always_ff @(posedge clk) begin
    if (load_fire && (load.position < tlen_eff)) begin
      target_store[AW'(load.position)] <= load.target_symbol;
    end
    tsym_q <= target_store[t_rd_addr];
  end

  // column feeder in front of the first cell
  always_ff @(posedge clk) begin
    if (rst || start) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= feed;
    end
    f_x <= LW'(cnt);
  end

  assign f_cost = CW'(f_x);
  assign f_diag = CW'(f_x) - CW'(1);

  for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
    cell_ctl_t ctl;
    logic          li_valid;
    logic [LW-1:0] li_x;
    logic [CW-1:0] li_cost, li_diag;
    logic [7:0]    li_sym;

    assign ctl.init    = start;
    assign ctl.base_we = load_fire && (load.position < blen_eff) && (32'(load.position) == k);

    if (k == 0) begin : g_head
      assign li_valid = f_valid;
      assign li_x     = f_x;
      assign li_cost  = f_cost;
      assign li_diag  = f_diag;
      assign li_sym   = tsym_q;
    end else begin : g_link
      assign li_valid = c_valid[k-1];
      assign li_x     = c_x[k-1];
      assign li_cost  = c_cost[k-1];
      assign li_diag  = c_diag[k-1];
      assign li_sym   = c_sym[k-1];
    end

    edt_cell #(.MAX_LEN(MAX_LEN), .CELL_IDX(k)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .load_sym (load.base_symbol),
      .i_valid  (li_valid),
      .i_x      (li_x),
      .i_cost   (li_cost),
      .i_diag   (li_diag),
      .i_sym    (li_sym),
      .rd_x     (tx),
      .o_valid  (c_valid[k]),
      .o_x      (c_x[k]),
      .o_cost   (c_cost[k]),
      .o_diag   (c_diag[k]),
      .o_sym    (c_sym[k]),
      .base_sym (c_bsym[k]),
      .cost     (c_own[k]),
      .rd_marks (c_marks[k])
    );
  end

  // traceback decision
  assign ysel = AW'(ty - LW'(1));
  assign bsel = AW'(blen_q - LW'(1));
  assign m_sel = c_marks[ysel];

  always_comb begin
    nx   = tx;
    ny   = ty;
    kind = KIND_REMOVE;
    sym  = tsym_q;
    if (ty == '0) begin
      nx = tx - LW'(1);
    end else if (tx == '0) begin
      kind = KIND_INSERT;
      sym  = c_bsym[ysel];
      ny   = ty - LW'(1);
    end else if (m_sel[MARK_MATCH_BIT]) begin
      kind = KIND_MATCH;
      nx   = tx - LW'(1);
      ny   = ty - LW'(1);
    end else if (m_sel[MARK_INSERT_BIT]) begin
      kind = KIND_INSERT;
      sym  = c_bsym[ysel];
      ny   = ty - LW'(1);
    end else begin
      nx = tx - LW'(1);
    end
  end

  assign tw = {6'd0, ty} - (LW+6)'(1);
  assign dw = (blen_q == '0) ? {6'd0, CW'(tlen_q)} : {6'd0, c_own[bsel]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (start) state_next = ST_FILL;
      ST_FILL: begin
        if (fill_done) begin
          state_next = ((blen_q == '0) && (tlen_q == '0)) ? ST_IDLE : ST_READ;
        end
      end
      ST_READ: state_next = ST_EMIT;
      ST_EMIT: begin
        if (emit_fire) begin
          state_next = ((nx == '0) && (ny == '0)) ? ST_IDLE : ST_READ;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (start) begin
      blen_q <= blen_eff;
      tlen_q <= tlen_eff;
      cnt    <= '0;
    end else if (state == ST_FILL) begin
      cnt <= cnt + CNW'(1);
    end
    if (fill_done) begin
      tx     <= tlen_q;
      ty     <= blen_q;
      dist_q <= dw[5:0];
    end else if (emit_fire) begin
      tx <= nx;
      ty <= ny;
    end
  end

  // output register; hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (emit_fire) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      result.op_kind    <= kind;
      result.op_symbol  <= sym;
      result.base_index <= tw[4:0];
      result.distance   <= dist_q;
      result.last_op    <= (nx == '0) && (ny == '0);
    end
  end

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    emit_fire && (nx == '0) && (ny == '0) |=> state == ST_IDLE)
    else $error("traceback did not stop after the final operation");

  a_trace_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ || state == ST_EMIT) |-> (tx <= tlen_q) && (ty <= blen_q))
    else $error("traceback position left the table");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_FILL |-> cnt <= fill_end)
    else $error("fill counter overran");

  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL) |-> !load_fire)
    else $error("load taken during table fill");

endmodule

@@ tb/tb_indel_edit_distance_traceback.sv @@
// Self-checking testbench for the indel edit-distance traceback block.
`timescale 1ns / 100ps

module tb_indel_edit_distance_traceback;
  import edt_pkg::*;

  localparam int MAXL = MAX_LEN_DEF;
  localparam int SETTLE_CYCLES = 3 * MAXL + 40;
  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 290;

  typedef struct {
    logic [1:0]        kind;
    logic [7:0]        sym;
    logic signed [4:0] idx;
    logic [5:0]        total;
    logic              last;
  } trace_op_t;

  typedef struct {
    int        blen;
    int        tlen;
    bit [3:0]  pos;
    bit [7:0]  bsym;
    bit [7:0]  tsym;
    bit        last;
    int        n_typed;   // -1: results come from the predictor
    trace_op_t typed [2];
  } load_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_index;
  logic [4:0] cfg_data;

  edt_load_if   load ();
  edt_result_if result ();

  indel_edit_distance_traceback dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .load     (load),
    .result   (result)
  );

  // Predictor state
  logic [7:0] base_mem [MAXL];
  logic [7:0] target_mem [MAXL];
  logic [4:0] base_len_reg;
  logic [4:0] target_len_reg;
  trace_op_t  pending_ops [$];

  int errors;
  int idle_pct;
  int stall_pct;
  int loads_done;
  int ops_seen;
  int tracebacks;
  int quiet_cycles;
  trace_op_t no_ops [2];
  load_row_t dir_rows [$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Store one load and, on the last one, push the traceback it produces.
  task automatic predict_traceback(input bit [3:0] pos, input bit [7:0] bsym,
                                   input bit [7:0] tsym, input bit last, input bit push);
    int blen, tlen, x, y, diag, ins, rem, best;
    int cost [MAXL + 1];
    logic [2:0] marks [MAXL + 1][MAXL + 1];
    logic [2:0] m;
    bit can_match;
    trace_op_t op;
    blen = (base_len_reg > MAXL) ? MAXL : base_len_reg;
    tlen = (target_len_reg > MAXL) ? MAXL : target_len_reg;
    if (pos < blen) base_mem[pos] = bsym;
    if (pos < tlen) target_mem[pos] = tsym;
    if (!last) return;
    tracebacks++;
    for (y = 0; y <= blen; y++) begin
      cost[y] = y;
      marks[0][y] = '0;
      if (y != 0) marks[0][y][MARK_INSERT_BIT] = 1'b1;
    end
    for (x = 1; x <= tlen; x++) begin
      diag = cost[0];
      cost[0] = x;
      marks[x][0] = '0;
      marks[x][0][MARK_REMOVE_BIT] = 1'b1;
      for (y = 1; y <= blen; y++) begin
        ins = cost[y - 1] + 1;
        rem = cost[y] + 1;
        can_match = base_mem[y - 1] == target_mem[x - 1];
        best = (ins < rem) ? ins : rem;
        if (can_match && diag < best) best = diag;
        m = '0;
        m[MARK_INSERT_BIT] = (ins == best);
        m[MARK_REMOVE_BIT] = (rem == best);
        m[MARK_MATCH_BIT]  = can_match && (diag == best);
        diag = cost[y];
        cost[y] = best;
        marks[x][y] = m;
      end
    end
    x = tlen;
    y = blen;
    while (x > 0 || y > 0) begin
      m = marks[x][y];
      op.idx = 5'(y - 1);
      // Prefer match, then insert, then remove.
      if (m[MARK_MATCH_BIT] && x > 0 && y > 0) begin
        op.kind = KIND_MATCH;
        op.sym = target_mem[x - 1];
        x--;
        y--;
      end else if (m[MARK_INSERT_BIT] && y > 0) begin
        op.kind = KIND_INSERT;
        op.sym = base_mem[y - 1];
        y--;
      end else if (x > 0) begin
        op.kind = KIND_REMOVE;
        op.sym = target_mem[x - 1];
        x--;
      end else begin
        op.kind = KIND_INSERT;
        op.sym = base_mem[y - 1];
        y--;
      end
      op.total = 6'(cost[blen]);
      op.last = (x == 0 && y == 0);
      if (push) pending_ops.push_back(op);
    end
  endtask

  task automatic send_load(input bit [3:0] pos, input bit [7:0] bsym, input bit [7:0] tsym,
                           input bit last, input int n_typed, input trace_op_t typed [2]);
    while ($urandom_range(99) < idle_pct) begin
      load.valid <= 1'b0;
      @(posedge clk);
    end
    load.valid         <= 1'b1;
    load.position      <= pos;
    load.base_symbol   <= bsym;
    load.target_symbol <= tsym;
    load.last_load     <= last;
    @(posedge clk);
    while (!load.ready) @(posedge clk);
    loads_done++;
    predict_traceback(pos, bsym, tsym, last, n_typed < 0);
    for (int i = 0; i < n_typed; i++) pending_ops.push_back(typed[i]);
  endtask

  // Drain the block, then let any result-free fill finish before touching registers.
  task automatic wait_idle();
    load.valid <= 1'b0;
    while (pending_ops.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_lengths(input int blen, input int tlen);
    if (blen == base_len_reg && tlen == target_len_reg) return;
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_BASE_LEN;
    cfg_data  <= 5'(blen);
    @(posedge clk);
    cfg_index <= REG_TARGET_LEN;
    cfg_data  <= 5'(tlen);
    @(posedge clk);
    cfg_we <= 1'b0;
    base_len_reg   = 5'(blen);
    target_len_reg = 5'(tlen);
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 4) return 0;
    if (r < 9) return 31;
    if (r < 18) return MAXL;
    if (r < 24) return $urandom_range(17, 30);
    return $urandom_range(1, 6);
  endfunction

  function automatic bit [7:0] pick_sym();
    if ($urandom_range(99) < 70) return 8'($urandom_range(8'h41, 8'h44));
    return 8'($urandom_range(255));
  endfunction

  function automatic void add_row(input int blen, input int tlen, input bit [3:0] pos,
                                  input bit [7:0] bsym, input bit [7:0] tsym, input bit last,
                                  input int n_typed, input trace_op_t t0, input trace_op_t t1);
    load_row_t r;
    r.blen = blen;
    r.tlen = tlen;
    r.pos = pos;
    r.bsym = bsym;
    r.tsym = tsym;
    r.last = last;
    r.n_typed = n_typed;
    r.typed[0] = t0;
    r.typed[1] = t1;
    dir_rows.push_back(r);
  endfunction

  // Result checker
  always @(posedge clk) begin
    if (!rst && result.valid && result.ready) begin
      trace_op_t want;
      ops_seen++;
      if (pending_ops.size() == 0) begin
        $error("unexpected result transaction: op_kind %0d op_symbol %0h",
               result.op_kind, result.op_symbol);
        errors++;
      end else begin
        want = pending_ops.pop_front();
        if (result.op_kind !== want.kind) begin
          $error("op_kind: expected %0d, got %0d", want.kind, result.op_kind);
          errors++;
        end
        if (result.op_symbol !== want.sym) begin
          $error("op_symbol: expected %0h, got %0h", want.sym, result.op_symbol);
          errors++;
        end
        if (result.base_index !== want.idx) begin
          $error("base_index: expected %0d, got %0d", want.idx, result.base_index);
          errors++;
        end
        if (result.distance !== want.total) begin
          $error("distance: expected %0d, got %0d", want.total, result.distance);
          errors++;
        end
        if (result.last_op !== want.last) begin
          $error("last_op: expected %0d, got %0d", want.last, result.last_op);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) result.ready <= 1'b0;
    else result.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: count cycles with no transaction on either channel.
  always @(posedge clk) begin
    if (rst || (load.valid && load.ready) || (result.valid && result.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    trace_op_t match_aa, ins_ff, rem_00;
    int blen, tlen, n, rnd_done, pos;
    bit last;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_BASE_LEN;
    cfg_data = '0;
    load.valid = 1'b0;
    load.position = '0;
    load.base_symbol = '0;
    load.target_symbol = '0;
    load.last_load = 1'b0;
    errors = 0;
    idle_pct = 0;
    stall_pct = 0;
    loads_done = 0;
    ops_seen = 0;
    tracebacks = 0;
    quiet_cycles = 0;
    base_len_reg = 5'd15;
    target_len_reg = 5'd15;
    no_ops[0] = '{KIND_MATCH, 8'h00, 5'sd0, 6'd0, 1'b0};
    no_ops[1] = no_ops[0];
    match_aa = '{KIND_MATCH, 8'hAA, 5'sd0, 6'd0, 1'b1};
    ins_ff   = '{KIND_INSERT, 8'hFF, 5'sd0, 6'd2, 1'b0};
    rem_00   = '{KIND_REMOVE, 8'h00, -5'sd1, 6'd2, 1'b1};

    // Fill every store entry first; oversize lengths saturate to the full width.
    for (int i = 0; i < MAXL; i++)
      add_row(31, 31, 4'(i), (i % 2) ? 8'hFF : 8'h00, (i % 3) ? 8'h00 : 8'hFF, i == MAXL - 1,
              -1, no_ops[0], no_ops[0]);
    add_row(1, 1, 4'd0, 8'hAA, 8'hAA, 1'b1, 1, match_aa, no_ops[0]);
    add_row(1, 1, 4'd0, 8'hFF, 8'h00, 1'b1, 2, ins_ff, rem_00);
    add_row(0, 0, 4'd0, 8'h12, 8'h34, 1'b1, 0, no_ops[0], no_ops[0]);
    add_row(0, 16, 4'd3, 8'h55, 8'h66, 1'b1, -1, no_ops[0], no_ops[0]);
    add_row(16, 0, 4'd15, 8'h77, 8'h88, 1'b1, -1, no_ops[0], no_ops[0]);
    add_row(5, 9, 4'd12, 8'h99, 8'hAB, 1'b0, -1, no_ops[0], no_ops[0]);
    add_row(5, 9, 4'd7, 8'hCD, 8'hEF, 1'b1, -1, no_ops[0], no_ops[0]);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      set_lengths(dir_rows[i].blen, dir_rows[i].tlen);
      send_load(dir_rows[i].pos, dir_rows[i].bsym, dir_rows[i].tsym, dir_rows[i].last,
                dir_rows[i].n_typed, dir_rows[i].typed);
    end

    rnd_done = 0;
    while (rnd_done < RANDOM_ITEMS) begin
      case (rnd_done * 4 / RANDOM_ITEMS)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 68; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 68; end
        default: begin idle_pct = 6; stall_pct = 6; end
      endcase
      if ($urandom_range(99) < 15) begin
        // Noise: stray position, occasional early last.
        send_load(4'($urandom_range(15)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                  $urandom_range(99) < 20, -1, no_ops);
        rnd_done++;
      end else begin
        set_lengths(pick_len(), pick_len());
        blen = (base_len_reg > MAXL) ? MAXL : base_len_reg;
        tlen = (target_len_reg > MAXL) ? MAXL : target_len_reg;
        n = (blen > tlen) ? blen : tlen;
        if (n == 0) n = 1;
        for (int i = 0; i < n; i++) begin
          pos = i;
          last = (i == n - 1);
          send_load(4'(pos), pick_sym(), pick_sym(), last, -1, no_ops);
          rnd_done++;
        end
      end
    end

    load.valid <= 1'b0;
    while (pending_ops.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d loads, %0d tracebacks, %0d result operations checked",
             loads_done, tracebacks, ops_seen);
    $display("lengths from empty through saturated, under four sender/receiver idle mixes");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
